// ----- sv/vfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types and constants of the voxel face-culling mesher: item and
// result structs, the internal command word, face directions and queue sizes.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int COORD_W        = 4;
  localparam int VALUE_W        = 8;
  localparam int DIR_W          = 3;
  localparam int NUM_DIRS       = 6;
  localparam int BLOCK_BITS_MAX = 16;
  localparam int CMDQ_DEPTH     = 2;
  localparam int OUTQ_DEPTH     = 8;
  localparam int MAX_FACES      = 6;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MESH  = 1'b1;

  typedef enum logic [DIR_W-1:0] {
    DIR_NEG_X,
    DIR_POS_X,
    DIR_NEG_Y,
    DIR_POS_Y,
    DIR_NEG_Z,
    DIR_POS_Z
  } dir_t;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] voxel_x;
    logic [COORD_W-1:0] voxel_y;
    logic [COORD_W-1:0] voxel_z;
    logic [VALUE_W-1:0] block_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_z;
    logic [DIR_W-1:0]   face_direction;
    logic               face_present;
    logic               last;
  } out_item_t;

  // classified item as it crosses from front to back
  typedef struct packed {
    in_item_t            item;
    logic                in_chunk;
    logic [NUM_DIRS-1:0] nbr_in;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MESH,
    BK_FLUSH
  } back_state_t;

  function automatic out_item_t make_result(
    input logic [COORD_W-1:0] x,
    input logic [COORD_W-1:0] y,
    input logic [COORD_W-1:0] z,
    input dir_t               dir,
    input logic               present,
    input logic               last_flag
  );
    out_item_t r;
    r.face_x         = x;
    r.face_y         = y;
    r.face_z         = z;
    r.face_direction = dir;
    r.face_present   = present;
    r.last           = last_flag;
    return r;
  endfunction

endpackage

// ----- sv/vfcm_front.sv -----
// ----------------------------------------------------------------------------
// vfcm_front
// Accepts input items, works out chunk and neighbour bounds for each and
// holds the classified commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module vfcm_front #(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 16,
  parameter int SIZE_Z = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  vfcm_pkg::in_item_t  in_item,
  input  logic                clearing,
  output logic                cmd_valid,
  output vfcm_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);

  localparam int PTR_W = $clog2(vfcm_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(vfcm_pkg::CMDQ_DEPTH + 1);

  vfcm_pkg::cmd_t   cls_cmd;
  vfcm_pkg::cmd_t   cmdq_r [vfcm_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;

  // bounds of the named voxel and of its six neighbours
  always_comb begin
    cls_cmd.item      = in_item;
    cls_cmd.in_chunk  = (32'(in_item.voxel_x) < SIZE_X) &&
                        (32'(in_item.voxel_y) < SIZE_Y) &&
                        (32'(in_item.voxel_z) < SIZE_Z);
    cls_cmd.nbr_in[0] = in_item.voxel_x != '0;
    cls_cmd.nbr_in[1] = (32'(in_item.voxel_x) + 32'd1) < SIZE_X;
    cls_cmd.nbr_in[2] = in_item.voxel_y != '0;
    cls_cmd.nbr_in[3] = (32'(in_item.voxel_y) + 32'd1) < SIZE_Y;
    cls_cmd.nbr_in[4] = in_item.voxel_z != '0;
    cls_cmd.nbr_in[5] = (32'(in_item.voxel_z) + 32'd1) < SIZE_Z;
  end

  // input transfer, held off during the clearing pass
  assign in_full   = (cnt_r == CNT_W'(vfcm_pkg::CMDQ_DEPTH)) || clearing;
  assign push      = in_push && !in_full;
  assign cmd_valid = cnt_r != '0;
  assign cmd       = cmdq_r[rd_ptr_r];

  // command queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmdq_r[wr_ptr_r] <= cls_cmd;
    end
  end

  // command queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !cmd_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push && cmd_pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/vfcm_back.sv -----
// ----------------------------------------------------------------------------
// vfcm_back
// Owns the single-ported voxel store. Clears it after reset, performs
// writes, and for a mesh command reads the voxel and its six neighbours and
// issues one result per exposed face, or one blank result if none is exposed.
// ----------------------------------------------------------------------------
module vfcm_back #(
  parameter int SIZE_X     = 16,
  parameter int SIZE_Y     = 16,
  parameter int SIZE_Z     = 16,
  parameter int BLOCK_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  vfcm_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  output logic                 clearing,
  input  logic                 room,
  output logic                 res_push,
  output vfcm_pkg::out_item_t  res
);

  localparam int CELLS    = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int AW       = $clog2(CELLS);
  localparam int STRIDE_Y = SIZE_X * SIZE_Z;
  localparam logic [AW-1:0] STEP_X_A = AW'(1);
  localparam logic [AW-1:0] STEP_Z_A = AW'(SIZE_X);
  localparam logic [AW-1:0] STEP_Y_A = AW'(STRIDE_Y);
  localparam logic [2:0]    STEP_LAST = 3'(vfcm_pkg::NUM_DIRS);

  vfcm_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  vfcm_pkg::cmd_t        cur_r, cur_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  vfcm_pkg::dir_t        pend_dir_r, pend_dir_nxt;

  logic [BLOCK_BITS-1:0] mem_r [CELLS];
  logic [BLOCK_BITS-1:0] rd_q_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [BLOCK_BITS-1:0] mem_wdata;

  logic [31:0]                         head_lin;
  logic [AW-1:0]                       head_addr;
  logic [vfcm_pkg::BLOCK_BITS_MAX-1:0] head_val;
  logic [AW-1:0]                       nbr_addr;
  logic [2:0]                          nbr_idx;
  logic                                exposed;

  // linear address of the command at the queue head
  assign head_lin  = 32'(cmd.item.voxel_x) + 32'(cmd.item.voxel_z) * 32'(SIZE_X) +
                     32'(cmd.item.voxel_y) * 32'(STRIDE_Y);
  assign head_addr = head_lin[AW-1:0];
  assign head_val  = vfcm_pkg::BLOCK_BITS_MAX'(cmd.item.block_value);

  // neighbour address for the read issued in this step
  always_comb begin
    unique case (step_r)
      3'd0:    nbr_addr = base_r - STEP_X_A;
      3'd1:    nbr_addr = base_r + STEP_X_A;
      3'd2:    nbr_addr = base_r - STEP_Y_A;
      3'd3:    nbr_addr = base_r + STEP_Y_A;
      3'd4:    nbr_addr = base_r - STEP_Z_A;
      3'd5:    nbr_addr = base_r + STEP_Z_A;
      default: nbr_addr = base_r;
    endcase
  end

  // neighbour whose data returns in this step, empty if outside the chunk
  assign nbr_idx = step_r - 3'd1;
  assign exposed = !cur_r.nbr_in[nbr_idx] || (rd_q_r == '0);

  // voxel store, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    rd_q_r <= mem_r[mem_addr];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vfcm_pkg::BK_CLEAR;
      clr_addr_r   <= '0;
      step_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      step_r       <= step_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // command payload registers
  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    cur_r      <= cur_nxt;
    pend_dir_r <= pend_dir_nxt;
  end

  // sequencer: next state and outputs
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    step_nxt       = step_r;
    base_nxt       = base_r;
    cur_nxt        = cur_r;
    pend_valid_nxt = pend_valid_r;
    pend_dir_nxt   = pend_dir_r;
    mem_we         = 1'b0;
    mem_addr       = head_addr;
    mem_wdata      = head_val[BLOCK_BITS-1:0];
    cmd_pop        = 1'b0;
    clearing       = 1'b0;
    res_push       = 1'b0;
    res            = vfcm_pkg::make_result(cur_r.item.voxel_x, cur_r.item.voxel_y,
                                           cur_r.item.voxel_z, vfcm_pkg::DIR_NEG_X,
                                           1'b0, 1'b1);
    unique case (state_r)
      vfcm_pkg::BK_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          state_nxt = vfcm_pkg::BK_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      vfcm_pkg::BK_IDLE: begin
        // a mesh command starts only when its results all fit downstream
        if (cmd_valid && (cmd.item.operation == vfcm_pkg::OP_WRITE || room)) begin
          cmd_pop = 1'b1;
          if (cmd.item.operation == vfcm_pkg::OP_MESH) begin
            cur_nxt        = cmd;
            base_nxt       = head_addr;
            pend_valid_nxt = 1'b0;
            if (cmd.in_chunk) begin
              step_nxt  = '0;
              state_nxt = vfcm_pkg::BK_MESH;
            end else begin
              res_push = 1'b1;
              res      = vfcm_pkg::make_result(cmd.item.voxel_x, cmd.item.voxel_y,
                                               cmd.item.voxel_z, vfcm_pkg::DIR_NEG_X,
                                               1'b0, 1'b1);
            end
          end else begin
            mem_we = cmd.in_chunk;
          end
        end
      end
      vfcm_pkg::BK_MESH: begin
        mem_addr = nbr_addr;
        if (step_r == 3'd0) begin
          // the named voxel itself
          if (rd_q_r == '0) begin
            res_push  = 1'b1;
            state_nxt = vfcm_pkg::BK_IDLE;
          end else begin
            step_nxt = 3'd1;
          end
        end else begin
          // hold back the newest face so the final one can carry last
          if (exposed) begin
            if (pend_valid_r) begin
              res_push = 1'b1;
              res      = vfcm_pkg::make_result(cur_r.item.voxel_x, cur_r.item.voxel_y,
                                               cur_r.item.voxel_z, pend_dir_r,
                                               1'b1, 1'b0);
            end
            pend_valid_nxt = 1'b1;
            pend_dir_nxt   = vfcm_pkg::dir_t'(nbr_idx);
          end
          if (step_r == STEP_LAST) begin
            state_nxt = vfcm_pkg::BK_FLUSH;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      vfcm_pkg::BK_FLUSH: begin
        res_push  = 1'b1;
        state_nxt = vfcm_pkg::BK_IDLE;
        if (pend_valid_r) begin
          res = vfcm_pkg::make_result(cur_r.item.voxel_x, cur_r.item.voxel_y,
                                      cur_r.item.voxel_z, pend_dir_r, 1'b1, 1'b1);
        end
      end
      default: begin
        state_nxt = vfcm_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/vfcm_outq.sv -----
// ----------------------------------------------------------------------------
// vfcm_outq
// Result queue between the back end and the result ports. Reports room
// while a whole mesh item's worth of results still fits.
// ----------------------------------------------------------------------------
module vfcm_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_push,
  input  vfcm_pkg::out_item_t  res,
  output logic                 room,
  output logic                 out_empty,
  input  logic                 out_pop,
  output vfcm_pkg::out_item_t  out_item
);

  localparam int PTR_W = $clog2(vfcm_pkg::OUTQ_DEPTH);
  localparam int CNT_W = $clog2(vfcm_pkg::OUTQ_DEPTH + 1);

  vfcm_pkg::out_item_t buf_r [vfcm_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                pop;

  assign room      = cnt_r <= CNT_W'(vfcm_pkg::OUTQ_DEPTH - vfcm_pkg::MAX_FACES);
  assign out_empty = cnt_r == '0;
  assign out_item  = buf_r[rd_ptr_r];
  assign pop       = out_pop && !out_empty;

  // result storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (res_push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!res_push && pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/voxel_face_culling_mesher_core.sv -----
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_core
// Voxel store with face culling: write items fill the store, mesh items
// yield one result per exposed face of the named voxel, or one blank result if none.
//
//   channel  ports                         direction  transfer when
//   input    in_push, in_full, in_item     in         in_push && !in_full
//   result   out_empty, out_pop, out_item  out        out_pop && !out_empty
//
// A write takes one access of the voxel store port. A mesh item outside the
// chunk reads nothing from the store; one on a solid voxel takes seven
// reads through the single store port plus the last-face flush. After reset
// a clearing pass zeroes all SIZE_X*SIZE_Y*SIZE_Z cells (4096 by default);
// in_full stays high meanwhile.
// A mesh item waits in the command queue until the result queue has room
// for six results, so a stalled result side holds up meshing, and input
// too once the two-entry command queue has filled.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher_core #(
  parameter int SIZE_X     = 16,
  parameter int SIZE_Y     = 16,
  parameter int SIZE_Z     = 16,
  parameter int BLOCK_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  vfcm_pkg::in_item_t   in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output vfcm_pkg::out_item_t  out_item
);

  logic                cmd_valid;
  vfcm_pkg::cmd_t      cmd;
  logic                cmd_pop;
  logic                clearing;
  logic                room;
  logic                res_push;
  vfcm_pkg::out_item_t res;

  // front end: classify and queue
  vfcm_front #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .SIZE_Z (SIZE_Z)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back end: voxel store and face sequencer
  vfcm_back #(
    .SIZE_X     (SIZE_X),
    .SIZE_Y     (SIZE_Y),
    .SIZE_Z     (SIZE_Z),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .room      (room),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  vfcm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .room      (room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voxel face-culling mesher. A clocked driver
// feeds write and mesh requests from a pending queue, a shadow voxel store
// works out the faces each mesh request must yield, and a clocked monitor
// compares every result transfer field by field under varied pacing.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHUNK            = 16;
  localparam int IDLE_LIMIT       = 20000;
  localparam int RANDOM_PER_PHASE = 113;
  localparam int TAIL_CYCLES      = 32;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_push   = 1'b0;
  logic                in_full;
  vfcm_pkg::in_item_t  in_item   = '0;
  logic                out_empty;
  logic                out_pop   = 1'b0;
  vfcm_pkg::out_item_t out_item;

  // shadow copy of the chunk, indexed [x][y][z]
  logic [vfcm_pkg::VALUE_W-1:0] shadow_cells [CHUNK][CHUNK][CHUNK];

  vfcm_pkg::in_item_t  pending_requests [$];
  vfcm_pkg::out_item_t expected_faces [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int idle_cycles    = 0;
  int writes_seen    = 0;
  int meshes_seen    = 0;
  int faces_checked  = 0;
  int blanks_checked = 0;

  voxel_face_culling_mesher_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // neighbours outside the chunk count as empty
  function automatic logic cell_solid(int x, int y, int z);
    if (x < 0 || x >= CHUNK || y < 0 || y >= CHUNK || z < 0 || z >= CHUNK) return 1'b0;
    return shadow_cells[x][y][z] != '0;
  endfunction

  // update the shadow store or queue the faces of one mesh request
  function automatic void predict_faces(vfcm_pkg::in_item_t req);
    int                  x, y, z, nx, ny, nz;
    vfcm_pkg::out_item_t face;
    vfcm_pkg::out_item_t held;
    logic                have_held;
    x = 32'(req.voxel_x);
    y = 32'(req.voxel_y);
    z = 32'(req.voxel_z);
    have_held = 1'b0;
    held = '0;
    if (req.operation == vfcm_pkg::OP_WRITE) begin
      if (x < CHUNK && y < CHUNK && z < CHUNK) shadow_cells[x][y][z] = req.block_value;
      writes_seen++;
      return;
    end
    meshes_seen++;
    if (cell_solid(x, y, z)) begin
      for (int d = 0; d < vfcm_pkg::NUM_DIRS; d++) begin
        nx = x;
        ny = y;
        nz = z;
        case (vfcm_pkg::dir_t'(d))
          vfcm_pkg::DIR_NEG_X: nx = x - 1;
          vfcm_pkg::DIR_POS_X: nx = x + 1;
          vfcm_pkg::DIR_NEG_Y: ny = y - 1;
          vfcm_pkg::DIR_POS_Y: ny = y + 1;
          vfcm_pkg::DIR_NEG_Z: nz = z - 1;
          default:             nz = z + 1;
        endcase
        if (!cell_solid(nx, ny, nz)) begin
          // hold each face back one step so the final one can carry last
          if (have_held) expected_faces.push_back(held);
          face.face_x         = req.voxel_x;
          face.face_y         = req.voxel_y;
          face.face_z         = req.voxel_z;
          face.face_direction = vfcm_pkg::dir_t'(d);
          face.face_present   = 1'b1;
          face.last           = 1'b0;
          held = face;
          have_held = 1'b1;
        end
      end
    end
    if (!have_held) begin
      // empty or fully enclosed voxel: one blank result
      held.face_x         = req.voxel_x;
      held.face_y         = req.voxel_y;
      held.face_z         = req.voxel_z;
      held.face_direction = vfcm_pkg::DIR_NEG_X;
      held.face_present   = 1'b0;
    end
    held.last = 1'b1;
    expected_faces.push_back(held);
  endfunction

  // compare one result transfer with the oldest expected face
  function automatic void check_face(vfcm_pkg::out_item_t got);
    vfcm_pkg::out_item_t want;
    if (expected_faces.size() == 0) begin
      $error("unexpected result %h with nothing outstanding", got);
      err_count++;
      return;
    end
    want = expected_faces.pop_front();
    if (got.face_x !== want.face_x) begin
      $error("face_x: expected %0d, got %0d", want.face_x, got.face_x);
      err_count++;
    end
    if (got.face_y !== want.face_y) begin
      $error("face_y: expected %0d, got %0d", want.face_y, got.face_y);
      err_count++;
    end
    if (got.face_z !== want.face_z) begin
      $error("face_z: expected %0d, got %0d", want.face_z, got.face_z);
      err_count++;
    end
    if (got.face_direction !== want.face_direction) begin
      $error("face_direction: expected %0d, got %0d", want.face_direction,
             got.face_direction);
      err_count++;
    end
    if (got.face_present !== want.face_present) begin
      $error("face_present: expected %0d, got %0d", want.face_present, got.face_present);
      err_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      err_count++;
    end
    if (want.face_present) faces_checked++;
    else blanks_checked++;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      foreach (shadow_cells[i, j, k]) shadow_cells[i][j][k] = '0;
    end else begin
      if (in_push && !in_full) begin
        predict_faces(in_item);
        void'(pending_requests.pop_front());
      end
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_item <= pending_requests[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_face(out_item);
      out_pop <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_write(int x, int y, int z, int value);
    vfcm_pkg::in_item_t req;
    req.operation   = vfcm_pkg::OP_WRITE;
    req.voxel_x     = vfcm_pkg::COORD_W'(x);
    req.voxel_y     = vfcm_pkg::COORD_W'(y);
    req.voxel_z     = vfcm_pkg::COORD_W'(z);
    req.block_value = vfcm_pkg::VALUE_W'(value);
    pending_requests.push_back(req);
  endtask

  task automatic queue_mesh(int x, int y, int z);
    vfcm_pkg::in_item_t req;
    req.operation   = vfcm_pkg::OP_MESH;
    req.voxel_x     = vfcm_pkg::COORD_W'(x);
    req.voxel_y     = vfcm_pkg::COORD_W'(y);
    req.voxel_z     = vfcm_pkg::COORD_W'(z);
    req.block_value = vfcm_pkg::VALUE_W'($urandom_range(0, 255));
    pending_requests.push_back(req);
  endtask

  // clusters near the centre and the corners keep neighbours often solid
  function automatic logic [vfcm_pkg::COORD_W-1:0] pick_coord(int region);
    case (region)
      0, 1: return vfcm_pkg::COORD_W'($urandom_range(6, 9));
      2:    return $urandom_range(0, 1) ? vfcm_pkg::COORD_W'($urandom_range(0, 1)) :
                                          vfcm_pkg::COORD_W'($urandom_range(14, 15));
      default: return vfcm_pkg::COORD_W'($urandom_range(0, CHUNK - 1));
    endcase
  endfunction

  function automatic vfcm_pkg::in_item_t random_request();
    vfcm_pkg::in_item_t req;
    int                 region;
    region = $urandom_range(0, 3);
    req.operation   = $urandom_range(0, 1) ? vfcm_pkg::OP_MESH : vfcm_pkg::OP_WRITE;
    req.voxel_x     = pick_coord(region);
    req.voxel_y     = pick_coord(region);
    req.voxel_z     = pick_coord(region);
    req.block_value = ($urandom_range(0, 4) == 0) ? '0 :
                      vfcm_pkg::VALUE_W'($urandom_range(1, 255));
    return req;
  endfunction

  // wait until every request is taken and every face has come back
  task automatic drain();
    while (pending_requests.size() != 0 || expected_faces.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // enclosed voxel, then one side opened
    queue_write(5, 5, 5, 1);
    queue_write(4, 5, 5, 255);
    queue_write(6, 5, 5, 2);
    queue_write(5, 4, 5, 3);
    queue_write(5, 6, 5, 4);
    queue_write(5, 5, 4, 5);
    queue_write(5, 5, 6, 6);
    queue_mesh(5, 5, 5);
    queue_write(5, 5, 6, 0);
    queue_mesh(5, 5, 5);
    queue_mesh(5, 5, 6);
    // corners: faces at the chunk boundary are exposed
    queue_write(0, 0, 0, 255);
    queue_mesh(0, 0, 0);
    queue_write(0, 0, 1, 128);
    queue_mesh(0, 0, 0);
    queue_write(15, 15, 15, 170);
    queue_mesh(15, 15, 15);
    queue_mesh(15, 0, 15);
    queue_write(15, 15, 15, 0);
    queue_mesh(15, 15, 15);
    drain();

    // random requests under four pacing patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_requests.push_back(random_request());
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d voxel writes and %0d mesh requests over four pacing patterns",
             writes_seen, meshes_seen);
    $display("checked %0d exposed faces and %0d blank results", faces_checked, blanks_checked);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/vfcm_pkg.sv
sv/vfcm_front.sv
sv/vfcm_back.sv
sv/vfcm_outq.sv
sv/voxel_face_culling_mesher_core.sv
tb/testbench.sv
